FILE: hw/rtl/ffr_pkg.sv
// Shared types, constants and helpers for the fixed-length frame receiver.
// No dependencies; imported by the top level, the sequencer and the store.
`default_nettype none

package ffr_pkg;

	// Default ring store depth
	localparam int unsigned STORE_DEPTH_DEF = 32;
	// Widest store address the depth range can need
	localparam int unsigned ADDR_MAX_W = 8;
	// Width of the configuration register index
	localparam int unsigned CFG_IDX_W = 8;

	// Escape pair bytes
	localparam logic [7:0] ESC_BYTE = 8'h5C;
	localparam logic [7:0] CLEAR_BYTE = 8'h61;
	localparam logic [7:0] CAPTURE_BYTE = 8'h62;

	// Frame length after reset
	localparam logic [4:0] FRAME_LENGTH_RST = 5'd16;

	// Run kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_CAPTURE = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MARKER = 8'd0,
		REG_END_MARKER   = 8'd1,
		REG_FRAME_LENGTH = 8'd2,
		REG_CAPTURE_EN   = 8'd3
	} cfg_reg_t;

	// Live configuration seen by the sequencer
	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] end_marker;
		logic [4:0] frame_length;
		logic       capture_en;
	} cfg_t;

	// Request bundle from the sequencer to the store
	typedef struct packed {
		logic                  wr_en;
		logic [ADDR_MAX_W-1:0] wr_addr;
		logic [7:0]            wr_data;
		logic                  clr_all;
		logic                  ra_en;
		logic [ADDR_MAX_W-1:0] ra_addr;
		logic                  rb_en;
		logic [ADDR_MAX_W-1:0] rb_addr;
	} store_req_t;

	// Frame length modulo the store depth; at most eight compare and subtract steps
	// since the depth is at least 4 and the length below 32.
	function automatic logic [ADDR_MAX_W-1:0] flen_mod(input logic [4:0] fl,
			input int unsigned d);
		logic [ADDR_MAX_W:0] v;
		v = (ADDR_MAX_W+1)'(fl);
		for (int k = 0; k < 8; k++) begin
			if (v >= (ADDR_MAX_W+1)'(d)) begin
				v = v - (ADDR_MAX_W+1)'(d);
			end
		end
		return v[ADDR_MAX_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fixed_length_frame_receiver_top.sv
// Top level of the fixed-length frame receiver: configuration registers,
// sequencer and ring store. Depends on ffr_pkg, ffr_seq and ffr_store.
//
// Usage:
//   Input channel (in_valid/in_stall/rx_byte) takes one received byte per beat.
//   Output channel (out_valid/out_stall) carries out_byte, run_kind and run_last;
//   run_kind is 1 for a configuration capture run and 0 for a frame run, and
//   run_last flags the final byte of each run.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   write only while no byte is in work.
// Timing:
//   A byte is accepted only while idle. A capture run walks the stored bytes up to
//   the escape pair; an end marker adds the start check (S_CHECK reads the start
//   entry, S_CMP compares it) and, on a match, a frame run of frame_length beats.
//   Each output beat is one read of the store's first read port, so the walk runs
//   at one beat per cycle when not stalled.
//   in_stall stays high until the last beat of the byte's runs is issued.
// Reset:
//   Clears the pointer, the last-byte register, the configuration and every
//   valid bit of the store at once; no clearing pass is needed.
// Stall:
//   A stalled beat holds; the walk waits with it.
`default_nettype none

module fixed_length_frame_receiver_top #(
	parameter int unsigned STORE_DEPTH = ffr_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [7:0]                         out_byte,
	output logic                               run_kind,
	output logic                               run_last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ffr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);
	import ffr_pkg::*;

	localparam int unsigned AW = $clog2(STORE_DEPTH);
	localparam logic [ADDR_MAX_W-1:0] FLM_RST8 = flen_mod(FRAME_LENGTH_RST, STORE_DEPTH);

	cfg_t                  cfg_q;
	logic [AW-1:0]         flm_q;
	logic [ADDR_MAX_W-1:0] flm_new;
	store_req_t            req;
	logic [7:0]            rb_data;

	// Reduce a written frame length modulo the depth
	assign flm_new = flen_mod(cfg_data[4:0], STORE_DEPTH);

	// Take register writes; keep the frame length modulo the depth alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= 8'h00;
			cfg_q.end_marker   <= 8'h00;
			cfg_q.frame_length <= FRAME_LENGTH_RST;
			cfg_q.capture_en   <= 1'b0;
			flm_q              <= FLM_RST8[AW-1:0];
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_MARKER: begin
					cfg_q.start_marker <= cfg_data;
				end
				REG_END_MARKER: begin
					cfg_q.end_marker <= cfg_data;
				end
				REG_FRAME_LENGTH: begin
					cfg_q.frame_length <= cfg_data[4:0];
					flm_q <= flm_new[AW-1:0];
				end
				REG_CAPTURE_EN: begin
					cfg_q.capture_en <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	ffr_seq #(
		.DEPTH(STORE_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.flm      (flm_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.run_kind (run_kind),
		.run_last (run_last),
		.req      (req),
		.rb_data  (rb_data)
	);

	ffr_store #(
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ra_data(out_byte),
		.rb_data(rb_data)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/ffr_store.sv
// Ring store: one write port, two registered read ports, per-entry valid bits.
// Depends on ffr_pkg for the request bundle.
`default_nettype none

module ffr_store #(
	parameter int unsigned DEPTH = ffr_pkg::STORE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ffr_pkg::store_req_t req,
	output logic [7:0]              ra_data,
	output logic [7:0]              rb_data
);
	import ffr_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       ra_q;
	logic [7:0]       rb_q;

	logic [AW-1:0] wr_a;
	logic [AW-1:0] ra_a;
	logic [AW-1:0] rb_a;

	assign wr_a = req.wr_addr[AW-1:0];
	assign ra_a = req.ra_addr[AW-1:0];
	assign rb_a = req.rb_addr[AW-1:0];

	// Write the data array
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_a] <= req.wr_data;
		end
	end

	// Mark written entries; a clear drops every entry at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clr_all) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[wr_a] <= 1'b1;
		end
	end

	// Read both ports; an entry not written since the last clear reads as zero
	always_ff @(posedge clk) begin
		if (req.ra_en) begin
			ra_q <= vld_q[ra_a] ? mem[ra_a] : 8'h00;
		end
		if (req.rb_en) begin
			rb_q <= vld_q[rb_a] ? mem[rb_a] : 8'h00;
		end
	end

	assign ra_data = ra_q;
	assign rb_data = rb_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ffr_seq.sv
// Sequencer: accepts a byte, handles the escape pairs, checks and walks frames.
// Depends on ffr_pkg; drives ffr_store through a request bundle.
`default_nettype none

module ffr_seq #(
	parameter int unsigned DEPTH = ffr_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ffr_pkg::cfg_t              cfg,
	input  wire logic [$clog2(DEPTH)-1:0]   flm,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            run_kind,
	output logic                            run_last,
	output ffr_pkg::store_req_t             req,
	input  wire logic [7:0]                 rb_data
);
	import ffr_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = (AW > 5) ? AW : 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CAP,
		S_CHECK,
		S_CMP,
		S_FRAME
	} state_t;

	state_t        state_q;
	logic [AW-1:0] wp_q;
	logic [7:0]    prev_q;
	logic          frame_req_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          kind_q;
	logic          last_q;

	logic          accept;
	logic          escaped;
	logic          is_clr;
	logic          is_cap;
	logic          cap_run;
	logic          frame_req;
	logic [AW-1:0] wp_inc;
	logic [AW-1:0] wp_new;
	logic [AW:0]   diff;
	logic [AW:0]   diff_wrap;
	logic [AW-1:0] start_new;
	logic          run_active;
	logic          issue;
	logic          beat_last;
	logic [AW-1:0] rd_ptr_inc;

	// Decode the incoming byte
	always_comb begin
		accept    = (state_q == S_IDLE) && in_valid;
		escaped   = cfg.capture_en && (prev_q == ESC_BYTE);
		is_clr    = escaped && (rx_byte == CLEAR_BYTE);
		is_cap    = escaped && (rx_byte == CAPTURE_BYTE);
		wp_inc    = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
		wp_new    = is_clr ? '0 : wp_inc;
		cap_run   = is_cap && (wp_new > AW'(2));
		frame_req = (rx_byte == cfg.end_marker) && (cfg.frame_length != 5'd0);
		diff      = {1'b0, wp_new} - {1'b0, flm};
		diff_wrap = diff + (AW+1)'(DEPTH);
		start_new = (wp_new >= flm) ? diff[AW-1:0] : diff_wrap[AW-1:0];
	end

	// Advance through a run one beat per free output slot
	always_comb begin
		run_active = (state_q == S_CAP) || (state_q == S_FRAME);
		issue      = run_active && (!out_valid_q || !out_stall);
		beat_last  = (cnt_q == '0);
		rd_ptr_inc = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	end

	// Drive the store
	always_comb begin
		req.wr_en   = accept;
		req.wr_addr = ADDR_MAX_W'(wp_q);
		req.wr_data = rx_byte;
		req.clr_all = (accept && (is_clr || (is_cap && !cap_run)))
			|| ((state_q == S_CAP) && issue && beat_last);
		req.ra_en   = issue;
		req.ra_addr = ADDR_MAX_W'(rd_ptr_q);
		req.rb_en   = (state_q == S_CHECK);
		req.rb_addr = ADDR_MAX_W'(start_q);
	end

	// Hold state and the output beat flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			prev_q      <= 8'h00;
			frame_req_q <= 1'b0;
			start_q     <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_FRAME;
			last_q      <= 1'b0;
		end else begin
			// Issue a beat, or drop the current one once taken
			if (issue) begin
				out_valid_q <= 1'b1;
				last_q      <= beat_last;
				rd_ptr_q    <= rd_ptr_inc;
				cnt_q       <= cnt_q - 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						wp_q        <= wp_new;
						prev_q      <= rx_byte;
						frame_req_q <= frame_req;
						start_q     <= start_new;
						if (cap_run) begin
							state_q  <= S_CAP;
							rd_ptr_q <= '0;
							cnt_q    <= CW'(wp_new - AW'(3));
						end else if (frame_req) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CAP: begin
					if (issue) begin
						kind_q <= KIND_CAPTURE;
						if (beat_last) begin
							state_q <= frame_req_q ? S_CHECK : S_IDLE;
						end
					end
				end
				S_CHECK: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rb_data == cfg.start_marker) begin
						state_q  <= S_FRAME;
						rd_ptr_q <= start_q;
						cnt_q    <= CW'(cfg.frame_length - 5'd1);
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FRAME: begin
					if (issue) begin
						kind_q <= KIND_FRAME;
						if (beat_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign run_kind  = kind_q;
	assign run_last  = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ffr_checker.sv
// Port-level checks for the fixed-length frame receiver, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module ffr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] rx_byte,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       run_kind,
	input wire logic       run_last
);

	// A stalled beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(run_kind) && $stable(run_last))
		else $error("stalled output beat changed");

	// A fresh beat only comes from a walk, during which input is stalled
	a_beat_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output beat appeared while idle");

	// While a run is still open the block takes no new byte
	a_run_open_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> in_stall)
		else $error("input accepted in the middle of a run");

endmodule

bind fixed_length_frame_receiver_top ffr_checker u_ffr_checker (.*);

`default_nettype wire
